// ----- rtl/core/mpef_pkg.sv -----
package mpef_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [15:0] DEFAULT_WIDTH  = 16'd1024;
  localparam logic [15:0] DEFAULT_HEIGHT = 16'd768;

  typedef struct packed {
    logic              op;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [2:0]        button_bits;
    logic signed [7:0] wheel_delta;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              entry_valid;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic [2:0]        out_buttons;
    logic signed [7:0] out_wheel;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [2:0]  buttons;
    logic [7:0]  wheel;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_status_t;

endpackage

// ----- rtl/core/mpef_pointer.sv -----
module mpef_pointer (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  logic signed [7:0] delta_x,
  input  logic signed [7:0] delta_y,
  input  logic [15:0]       width,
  input  logic [15:0]       height,
  output logic [15:0]       x_next,
  output logic [15:0]       y_next
);
  import mpef_pkg::*;

  logic [15:0] pointer_x;
  logic [15:0] pointer_y;
  logic        started;

  logic [15:0]        base_x;
  logic [15:0]        base_y;
  logic signed [17:0] sum_x;
  logic signed [17:0] sum_y;
  logic [16:0]        hi_x;
  logic [16:0]        hi_y;

  // first move after reset starts from the screen centre
  assign base_x = started ? pointer_x : (width >> 1);
  assign base_y = started ? pointer_y : (height >> 1);

  assign sum_x = $signed({2'b00, base_x}) + $signed({{9{delta_x[7]}}, delta_x, 1'b0});
  assign sum_y = $signed({2'b00, base_y}) + $signed({{9{delta_y[7]}}, delta_y, 1'b0});
  assign hi_x  = {1'b0, width} - 17'd1;
  assign hi_y  = {1'b0, height} - 17'd1;

  always_comb begin
    if (sum_x[17]) begin
      x_next = 16'd0;
    end else if (sum_x[16:0] > hi_x) begin
      x_next = hi_x[15:0];
    end else begin
      x_next = sum_x[15:0];
    end
    if (sum_y[17]) begin
      y_next = 16'd0;
    end else if (sum_y[16:0] > hi_y) begin
      y_next = hi_y[15:0];
    end else begin
      y_next = sum_y[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x <= 16'd0;
      pointer_y <= 16'd0;
      started   <= 1'b0;
    end else if (update) begin
      pointer_x <= x_next;
      pointer_y <= y_next;
      started   <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/mpef_ring.sv -----
module mpef_ring #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mpef_pkg::entry_t      push_entry,
  input  logic                  pop,
  output mpef_pkg::ring_status_t status,
  output mpef_pkg::entry_t      rd_entry
);
  import mpef_pkg::*;

  localparam int unsigned AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  entry_t mem [DEPTH];

  logic [AW-1:0] read_index;
  logic [AW-1:0] write_index;
  logic [AW-1:0] write_index_next;
  logic [AW-1:0] read_index_next;

  assign write_index_next = (write_index == LAST) ? '0 : write_index + AW'(1);
  assign read_index_next  = (read_index == LAST) ? '0 : read_index + AW'(1);

  assign status.full  = (write_index_next == read_index);
  assign status.empty = (write_index == read_index);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[write_index] <= push_entry;
    end
    if (pop) begin
      rd_entry <= mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
    end else begin
      if (push) begin
        write_index <= write_index_next;
      end
      if (pop) begin
        read_index <= read_index_next;
      end
    end
  end

  a_push_not_full : assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("push into full ring");
  a_pop_not_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("pop from empty ring");
  a_push_fills : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !status.empty) else $error("ring empty after push");

endmodule

// ----- rtl/core/mouse_pointer_event_fifo.sv -----
// channel | direction | handshake            | beat
// in      | input     | in_valid / in_stall  | in_item_t: push report or pop request
// out     | output    | out_valid / out_stall| out_item_t: one result per input beat
// cfg     | input     | cfg_valid / cfg_ready| register index and 16-bit value
//
// a push does pointer add and clamp and writes the entry to the ring memory (dropped if full), answered the next cycle
// a pop of a non-empty ring reads the ring memory into rd_entry, then ST_READ loads the result register
// a pop of an empty ring is answered the next cycle
// one item in flight; input stalls while a pop read is pending or a result is held
// reset (rst, synchronous) empties the ring and clears the pointer; no clearing pass
module mouse_pointer_event_fifo #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  mpef_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output mpef_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mpef_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [15:0]                           cfg_data
);
  import mpef_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0] screen_width;
  logic [15:0] screen_height;
  logic [15:0] width_eff;
  logic [15:0] height_eff;

  logic         in_accept;
  logic         do_push;
  logic         do_pop;
  logic         drop;
  logic         empty_pop;
  ring_status_t ring_status;
  entry_t       push_entry;
  entry_t       rd_entry;
  logic [15:0]  x_next;
  logic [15:0]  y_next;

  logic      load;
  out_item_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DEFAULT_WIDTH;
      screen_height <= DEFAULT_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_eff  = (screen_width == 16'd0) ? DEFAULT_WIDTH : screen_width;
  assign height_eff = (screen_height == 16'd0) ? DEFAULT_HEIGHT : screen_height;

  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign do_push   = in_accept && (in_data.op == OP_PUSH) && !ring_status.full;
  assign drop      = in_accept && (in_data.op == OP_PUSH) && ring_status.full;
  assign do_pop    = in_accept && (in_data.op == OP_POP) && !ring_status.empty;
  assign empty_pop = in_accept && (in_data.op == OP_POP) && ring_status.empty;

  mpef_pointer u_pointer (
    .clk     (clk),
    .rst     (rst),
    .update  (do_push),
    .delta_x (in_data.delta_x),
    .delta_y (in_data.delta_y),
    .width   (width_eff),
    .height  (height_eff),
    .x_next  (x_next),
    .y_next  (y_next)
  );

  assign push_entry.x       = x_next;
  assign push_entry.y       = y_next;
  assign push_entry.buttons = in_data.button_bits;
  assign push_entry.wheel   = in_data.wheel_delta;

  mpef_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .push       (do_push),
    .push_entry (push_entry),
    .pop        (do_pop),
    .status     (ring_status),
    .rd_entry   (rd_entry)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_pop) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result = '0;
    load   = 1'b0;
    if (state == ST_READ) begin
      load               = 1'b1;
      result.entry_valid = 1'b1;
      result.pos_x       = rd_entry.x;
      result.pos_y       = rd_entry.y;
      result.out_buttons = rd_entry.buttons;
      result.out_wheel   = rd_entry.wheel;
    end else if (do_push || drop || empty_pop) begin
      load            = 1'b1;
      result.accepted = do_push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  a_read_slot_free : assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid || !out_stall) else $error("result slot busy on read");
  a_pop_to_read : assert property (@(posedge clk) disable iff (rst)
    do_pop |=> state == ST_READ) else $error("pop did not start a read");
  a_one_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.accepted && out_data.entry_valid))
    else $error("push and pop flags both set");
  a_read_gives_result : assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> out_valid && out_data.entry_valid) else $error("read lost");

endmodule
